// ===== hdl/kvt_pkg.sv =====
// Shared types and constants for the key-value text tokenizer.
`default_nettype none
package kvt_pkg;

  // Deepest block nesting accepted; the depth counter is 8 bits wide.
  localparam int MAX_DEPTH = 255;
  localparam logic [7:0] DEPTH_LIMIT = 8'((MAX_DEPTH < 255) ? MAX_DEPTH : 255);

  // Default width of the string buffer byte counter.
  localparam int TOTAL_BITS = 24;
  localparam int SHOWN_BITS = 24;

  // Character codes.
  localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE       = 8'h22;
  localparam logic [7:0] CH_SLASH       = 8'h2F;
  localparam logic [7:0] CH_FIRST_INK   = 8'h21;
  localparam logic [7:0] CH_LAST_INK    = 8'h7E;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_LF          = 8'h0A;
  localparam logic [7:0] CH_NUL         = 8'h00;

  typedef enum logic [5:0] {
    PH_GAP     = 6'b000001,
    PH_SLASH   = 6'b000010,
    PH_COMMENT = 6'b000100,
    PH_QUOTED  = 6'b001000,
    PH_BARE    = 6'b010000,
    PH_ERROR   = 6'b100000
  } kvt_phase_e;

  typedef enum logic [2:0] {
    CLS_SKIP  = 3'd0,
    CLS_KEY   = 3'd1,
    CLS_VALUE = 3'd2,
    CLS_OPEN  = 3'd3,
    CLS_CLOSE = 3'd4,
    CLS_END   = 3'd5
  } kvt_class_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_OPEN_STRING = 3'd1,
    ERR_STRAY_CLOSE = 3'd2,
    ERR_OPEN_BLOCK  = 3'd3,
    ERR_BAD_OPEN    = 3'd4,
    ERR_LONE_SLASH  = 3'd5,
    ERR_TOO_DEEP    = 3'd6
  } kvt_err_e;

  typedef struct packed {
    kvt_phase_e phase;
    logic       resume;   // 0: key position, 1: value position
    logic [7:0] depth;
    kvt_err_e   err;
  } kvt_state_t;

  typedef struct packed {
    kvt_class_e cls;
    logic       key_done;
    logic       value_done;
    logic [7:0] depth;
    kvt_err_e   err;
  } kvt_result_t;

  localparam kvt_state_t STATE_RESET = '{
    phase:  PH_GAP,
    resume: 1'b0,
    depth:  8'd0,
    err:    ERR_NONE
  };

endpackage
`default_nettype wire

// ===== hdl/keyvalue_text_tokenizer.sv =====
// Top level of the key-value text tokenizer: input stage, parser state, result stage.
//
// Streaming syntax checker for nested key-value text, one byte per beat.
// Input channel: data_byte_i with in_valid_i / in_ready_o. Output channel:
// echo_byte_o, byte_class_o, key_done_o, value_done_o, depth_now_o,
// error_code_o and string_total_o with out_valid_o / out_ready_i.
// Every input beat yields exactly one output beat. A zero byte ends the
// text: its beat carries class end-of-text and the final status, and the
// parser state is then cleared for the next text.
// A byte accepted on the input passes through two register stages, the input
// register and the result register, before it is presented on the output.
// Throughput: one byte per clock while out_ready_i holds; the parser step is
// combinational logic between the two registers, and the parser state feeds back through it.
// Receiver stall: the result register holds its beat; the input register
// keeps taking bytes until it is full, then in_ready_o drops.
// Reset: rst_ni clears both valid flags, the parser state, the depth, the
// latched error and the byte total; the block is ready as soon as reset is released.
`default_nettype none
module keyvalue_text_tokenizer #(
  parameter int TOTAL_BITS = kvt_pkg::TOTAL_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [7:0]       echo_byte_o,
  output logic [2:0]       byte_class_o,
  output logic             key_done_o,
  output logic             value_done_o,
  output logic [7:0]       depth_now_o,
  output logic [2:0]       error_code_o,
  output logic [23:0]      string_total_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  logic                                in_valid_q, in_valid_d;
  logic [7:0]                          in_byte_q;
  logic                                out_valid_q, out_valid_d;
  logic [7:0]                          echo_q;
  kvt_pkg::kvt_result_t                res_q;
  logic [kvt_pkg::SHOWN_BITS-1:0]      shown_q;
  kvt_pkg::kvt_state_t                 state_q, state_d;
  logic [TOTAL_BITS-1:0]               total_q, total_d;
  kvt_pkg::kvt_result_t                res_d;
  logic [kvt_pkg::SHOWN_BITS-1:0]      shown_d;
  logic                                advance;
  logic                                accept;

  // move the held byte into the result stage when that stage is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  kvt_step #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_step (
    .data_byte_i (in_byte_q),
    .state_i     (state_q),
    .total_i     (total_q),
    .state_o     (state_d),
    .total_o     (total_d),
    .result_o    (res_d),
    .shown_o     (shown_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= kvt_pkg::STATE_RESET;
      total_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
    end
    if (advance) begin
      echo_q  <= in_byte_q;
      res_q   <= res_d;
      shown_q <= shown_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign echo_byte_o    = echo_q;
  assign byte_class_o   = res_q.cls;
  assign key_done_o     = res_q.key_done;
  assign value_done_o   = res_q.value_done;
  assign depth_now_o    = res_q.depth;
  assign error_code_o   = res_q.err;
  assign string_total_o = shown_q;

endmodule
`default_nettype wire

// ===== hdl/kvt_step.sv =====
// Per-byte parser step: next state, byte class, done flags and total.
`default_nettype none
module kvt_step #(
  parameter int TOTAL_BITS = kvt_pkg::TOTAL_BITS
) (
  input  wire logic [7:0]                      data_byte_i,
  input  wire kvt_pkg::kvt_state_t             state_i,
  input  wire logic [TOTAL_BITS-1:0]           total_i,
  output kvt_pkg::kvt_state_t                  state_o,
  output logic [TOTAL_BITS-1:0]                total_o,
  output kvt_pkg::kvt_result_t                 result_o,
  output logic [kvt_pkg::SHOWN_BITS-1:0]       shown_o
);

  localparam int WideBits = (TOTAL_BITS > kvt_pkg::SHOWN_BITS) ? TOTAL_BITS
                                                                : kvt_pkg::SHOWN_BITS;
  localparam logic [WideBits-1:0] ShownMax = WideBits'({kvt_pkg::SHOWN_BITS{1'b1}});

  kvt_pkg::kvt_phase_e      ph;
  logic                     res;
  logic [7:0]               dep;
  kvt_pkg::kvt_err_e        err;
  kvt_pkg::kvt_err_e        err_out;
  kvt_pkg::kvt_class_e      cls;
  logic                     kd;
  logic                     vd;
  logic                     bump;
  logic                     fin;
  logic                     start;
  logic                     is_space;
  logic                     is_special;
  logic                     is_end;
  logic [TOTAL_BITS-1:0]    total_bumped;
  logic [WideBits-1:0]      total_wide;

  assign is_space   = (data_byte_i < kvt_pkg::CH_FIRST_INK) ||
                      (data_byte_i > kvt_pkg::CH_LAST_INK);
  assign is_special = (data_byte_i == kvt_pkg::CH_QUOTE) ||
                      (data_byte_i == kvt_pkg::CH_OPEN_BRACE) ||
                      (data_byte_i == kvt_pkg::CH_CLOSE_BRACE) ||
                      (data_byte_i == kvt_pkg::CH_SLASH);
  assign is_end     = (data_byte_i == kvt_pkg::CH_NUL);

  always_comb begin
    ph      = state_i.phase;
    res     = state_i.resume;
    dep     = state_i.depth;
    err     = state_i.err;
    err_out = state_i.err;
    cls     = kvt_pkg::CLS_SKIP;
    kd      = 1'b0;
    vd      = 1'b0;
    bump    = 1'b0;
    fin     = 1'b0;
    start   = 1'b0;

    if (is_end) begin
      if (ph != kvt_pkg::PH_ERROR) begin
        if (ph == kvt_pkg::PH_QUOTED) begin
          err_out = kvt_pkg::ERR_OPEN_STRING;
        end else if (ph == kvt_pkg::PH_SLASH) begin
          err_out = kvt_pkg::ERR_LONE_SLASH;
        end else begin
          // a bare token cut off by the end byte still completes
          if (ph == kvt_pkg::PH_BARE) begin
            bump = 1'b1;
            kd   = ~res;
            vd   = res;
          end
          if (dep != 8'd0) begin
            err_out = kvt_pkg::ERR_OPEN_BLOCK;
          end
        end
      end
      cls = kvt_pkg::CLS_END;
    end else begin
      case (ph)
        kvt_pkg::PH_GAP: begin
          start = 1'b1;
        end
        kvt_pkg::PH_SLASH: begin
          if (data_byte_i == kvt_pkg::CH_SLASH) begin
            ph = kvt_pkg::PH_COMMENT;
          end else begin
            err = kvt_pkg::ERR_LONE_SLASH;
            ph  = kvt_pkg::PH_ERROR;
          end
        end
        kvt_pkg::PH_COMMENT: begin
          if (data_byte_i == kvt_pkg::CH_CR || data_byte_i == kvt_pkg::CH_LF) begin
            ph = kvt_pkg::PH_GAP;
          end
        end
        kvt_pkg::PH_QUOTED: begin
          cls = res ? kvt_pkg::CLS_VALUE : kvt_pkg::CLS_KEY;
          if (data_byte_i == kvt_pkg::CH_QUOTE) begin
            fin = 1'b1;
          end else begin
            bump = 1'b1;
          end
        end
        kvt_pkg::PH_BARE: begin
          if (is_space || is_special) begin
            // end the token, then treat this byte as the start of the next item
            fin   = 1'b1;
            start = 1'b1;
          end else begin
            cls  = res ? kvt_pkg::CLS_VALUE : kvt_pkg::CLS_KEY;
            bump = 1'b1;
          end
        end
        default: begin
          ph = kvt_pkg::PH_ERROR;
        end
      endcase

      if (fin) begin
        bump = 1'b1;
        kd   = ~res;
        vd   = res;
        res  = ~res;
        ph   = kvt_pkg::PH_GAP;
      end

      if (start) begin
        cls = kvt_pkg::CLS_SKIP;
        if (is_space) begin
          ph = kvt_pkg::PH_GAP;
        end else if (data_byte_i == kvt_pkg::CH_SLASH) begin
          ph = kvt_pkg::PH_SLASH;
        end else if (data_byte_i == kvt_pkg::CH_QUOTE) begin
          ph  = kvt_pkg::PH_QUOTED;
          cls = res ? kvt_pkg::CLS_VALUE : kvt_pkg::CLS_KEY;
        end else if (data_byte_i == kvt_pkg::CH_OPEN_BRACE) begin
          if (!res) begin
            err = kvt_pkg::ERR_BAD_OPEN;
            ph  = kvt_pkg::PH_ERROR;
          end else if (dep >= kvt_pkg::DEPTH_LIMIT) begin
            err = kvt_pkg::ERR_TOO_DEEP;
            ph  = kvt_pkg::PH_ERROR;
          end else begin
            dep = dep + 8'd1;
            res = 1'b0;
            ph  = kvt_pkg::PH_GAP;
            cls = kvt_pkg::CLS_OPEN;
          end
        end else if (data_byte_i == kvt_pkg::CH_CLOSE_BRACE) begin
          if (res || dep == 8'd0) begin
            err = kvt_pkg::ERR_STRAY_CLOSE;
            ph  = kvt_pkg::PH_ERROR;
          end else begin
            dep = dep - 8'd1;
            ph  = kvt_pkg::PH_GAP;
            cls = kvt_pkg::CLS_CLOSE;
          end
        end else begin
          ph   = kvt_pkg::PH_BARE;
          cls  = res ? kvt_pkg::CLS_VALUE : kvt_pkg::CLS_KEY;
          bump = 1'b1;
        end
      end
      err_out = err;
    end
  end

  // at most one count per byte; hold at the counter's top value
  assign total_bumped = (bump && (total_i != {TOTAL_BITS{1'b1}})) ?
                        total_i + TOTAL_BITS'(1) : total_i;
  assign total_wide   = WideBits'(total_bumped);
  assign shown_o      = (total_wide >= ShownMax) ? {kvt_pkg::SHOWN_BITS{1'b1}}
                                                 : total_wide[kvt_pkg::SHOWN_BITS-1:0];

  always_comb begin
    if (is_end) begin
      state_o = kvt_pkg::STATE_RESET;
      total_o = '0;
    end else begin
      state_o.phase  = ph;
      state_o.resume = res;
      state_o.depth  = dep;
      state_o.err    = err;
      total_o        = total_bumped;
    end
  end

  assign result_o.cls        = cls;
  assign result_o.key_done   = kd;
  assign result_o.value_done = vd;
  assign result_o.depth      = is_end ? 8'd0 : dep;
  assign result_o.err        = err_out;

endmodule
`default_nettype wire

// ===== bench/keyvalue_text_tokenizer_checker.sv =====
// Scoreboard for the key-value text tokenizer: predicts every result beat and compares it.
`timescale 1ns / 1ps
module keyvalue_text_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  echo_byte_i,
  input  logic [2:0]  byte_class_i,
  input  logic        key_done_i,
  input  logic        value_done_i,
  input  logic [7:0]  depth_now_i,
  input  logic [2:0]  error_code_i,
  input  logic [23:0] string_total_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0]           echo;
    kvt_pkg::kvt_class_e  cls;
    logic                 key_done;
    logic                 value_done;
    logic [7:0]           depth;
    kvt_pkg::kvt_err_e    err;
    logic [23:0]          total;
  } tok_beat_t;

  // Tokenizer state as the predictor sees it
  kvt_pkg::kvt_phase_e  tok_phase;
  logic                 at_value;
  logic [7:0]           nest;
  kvt_pkg::kvt_err_e    held_err;
  logic [23:0]          buf_total;

  // Per-byte outcome
  kvt_pkg::kvt_class_e  beat_cls;
  logic                 key_end;
  logic                 value_end;

  tok_beat_t   expected_q[$];

  function automatic void clear_parser();
    tok_phase = kvt_pkg::PH_GAP;
    at_value  = 1'b0;
    nest      = 8'd0;
    held_err  = kvt_pkg::ERR_NONE;
    buf_total = '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c < kvt_pkg::CH_FIRST_INK) || (c > kvt_pkg::CH_LAST_INK);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == kvt_pkg::CH_QUOTE) || (c == kvt_pkg::CH_OPEN_BRACE) ||
           (c == kvt_pkg::CH_CLOSE_BRACE) || (c == kvt_pkg::CH_SLASH);
  endfunction

  function automatic kvt_pkg::kvt_class_e text_cls();
    return at_value ? kvt_pkg::CLS_VALUE : kvt_pkg::CLS_KEY;
  endfunction

  function automatic void bump_buf();
    if (buf_total != '1) buf_total = buf_total + 24'd1;
  endfunction

  function automatic void latch_err(input kvt_pkg::kvt_err_e code);
    held_err  = code;
    tok_phase = kvt_pkg::PH_ERROR;
    beat_cls  = kvt_pkg::CLS_SKIP;
  endfunction

  // Count the terminator slot and flip between key and value position
  function automatic void end_token();
    bump_buf();
    if (!at_value) begin
      key_end  = 1'b1;
      at_value = 1'b1;
    end else begin
      value_end = 1'b1;
      at_value  = 1'b0;
    end
    tok_phase = kvt_pkg::PH_GAP;
  endfunction

  function automatic void begin_item(input logic [7:0] c);
    beat_cls = kvt_pkg::CLS_SKIP;
    if (is_blank(c)) begin
      tok_phase = kvt_pkg::PH_GAP;
    end else if (c == kvt_pkg::CH_SLASH) begin
      tok_phase = kvt_pkg::PH_SLASH;
    end else if (c == kvt_pkg::CH_QUOTE) begin
      tok_phase = kvt_pkg::PH_QUOTED;
      beat_cls  = text_cls();
    end else if (c == kvt_pkg::CH_OPEN_BRACE) begin
      if (!at_value) begin
        latch_err(kvt_pkg::ERR_BAD_OPEN);
      end else if (nest >= kvt_pkg::DEPTH_LIMIT) begin
        latch_err(kvt_pkg::ERR_TOO_DEEP);
      end else begin
        nest      = nest + 8'd1;
        at_value  = 1'b0;
        tok_phase = kvt_pkg::PH_GAP;
        beat_cls  = kvt_pkg::CLS_OPEN;
      end
    end else if (c == kvt_pkg::CH_CLOSE_BRACE) begin
      if (at_value || nest == 8'd0) begin
        latch_err(kvt_pkg::ERR_STRAY_CLOSE);
      end else begin
        nest      = nest - 8'd1;
        tok_phase = kvt_pkg::PH_GAP;
        beat_cls  = kvt_pkg::CLS_CLOSE;
      end
    end else begin
      tok_phase = kvt_pkg::PH_BARE;
      beat_cls  = text_cls();
      bump_buf();
    end
  endfunction

  function automatic tok_beat_t tokenize_byte(input logic [7:0] c);
    tok_beat_t          r;
    kvt_pkg::kvt_err_e  final_err;
    beat_cls  = kvt_pkg::CLS_SKIP;
    key_end   = 1'b0;
    value_end = 1'b0;
    if (c == kvt_pkg::CH_NUL) begin
      final_err = held_err;
      if (tok_phase != kvt_pkg::PH_ERROR) begin
        if (tok_phase == kvt_pkg::PH_QUOTED) begin
          final_err = kvt_pkg::ERR_OPEN_STRING;
        end else if (tok_phase == kvt_pkg::PH_SLASH) begin
          final_err = kvt_pkg::ERR_LONE_SLASH;
        end else begin
          // a bare token cut off by the terminator still completes
          if (tok_phase == kvt_pkg::PH_BARE) end_token();
          if (nest != 8'd0) final_err = kvt_pkg::ERR_OPEN_BLOCK;
        end
      end
      r = '{echo: c, cls: kvt_pkg::CLS_END, key_done: key_end, value_done: value_end,
            depth: 8'd0, err: final_err, total: buf_total};
      clear_parser();
      return r;
    end
    case (tok_phase)
      kvt_pkg::PH_GAP:     begin_item(c);
      kvt_pkg::PH_SLASH: begin
        if (c == kvt_pkg::CH_SLASH) tok_phase = kvt_pkg::PH_COMMENT;
        else latch_err(kvt_pkg::ERR_LONE_SLASH);
      end
      kvt_pkg::PH_COMMENT: begin
        if (c == kvt_pkg::CH_CR || c == kvt_pkg::CH_LF) tok_phase = kvt_pkg::PH_GAP;
      end
      kvt_pkg::PH_QUOTED: begin
        beat_cls = text_cls();
        if (c == kvt_pkg::CH_QUOTE) end_token();
        else bump_buf();
      end
      kvt_pkg::PH_BARE: begin
        // the ending byte is examined again as the start of the next item
        if (is_blank(c) || is_delim(c)) begin
          end_token();
          begin_item(c);
        end else begin
          beat_cls = text_cls();
          bump_buf();
        end
      end
      default: tok_phase = kvt_pkg::PH_ERROR;
    endcase
    r = '{echo: c, cls: beat_cls, key_done: key_end, value_done: value_end,
          depth: nest, err: held_err, total: buf_total};
    return r;
  endfunction

  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      fail_count_o++;
      // limit log size on a badly broken build
      if (fail_count_o <= 200)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  initial begin
    clear_parser();
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tok_beat_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with nothing expected, expected none, got echo 0x%0h",
                   $time, echo_byte_i);
        end else begin
          want = expected_q.pop_front();
          check_field("echo_byte", 24'(want.echo), 24'(echo_byte_i));
          check_field("byte_class", 24'(want.cls), 24'(byte_class_i));
          check_field("key_done", 24'(want.key_done), 24'(key_done_i));
          check_field("value_done", 24'(want.value_done), 24'(value_done_i));
          check_field("depth_now", 24'(want.depth), 24'(depth_now_i));
          check_field("error_code", 24'(want.err), 24'(error_code_i));
          check_field("string_total", want.total, string_total_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(tokenize_byte(data_byte_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/keyvalue_text_tokenizer_tb.sv =====
// Testbench top for the key-value text tokenizer: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module keyvalue_text_tokenizer_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [7:0]  data_byte_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  echo_byte_o;
  logic [2:0]  byte_class_o;
  logic        key_done_o;
  logic        value_done_o;
  logic [7:0]  depth_now_o;
  logic [2:0]  error_code_o;
  logic [23:0] string_total_o;
  logic        out_valid_o;
  logic        out_ready_i;

  int          fail_count;
  int          pending_beats;
  int          sent_count = 0;
  bit          idle_on  = 1'b0;
  bit          stall_on = 1'b0;
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  text_q[$];

  always #6 clk_i = ~clk_i;

  keyvalue_text_tokenizer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .echo_byte_o    (echo_byte_o),
    .byte_class_o   (byte_class_o),
    .key_done_o     (key_done_o),
    .value_done_o   (value_done_o),
    .depth_now_o    (depth_now_o),
    .error_code_o   (error_code_o),
    .string_total_o (string_total_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  keyvalue_text_tokenizer_checker u_kvt_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .echo_byte_i    (echo_byte_o),
    .byte_class_i   (byte_class_o),
    .key_done_i     (key_done_o),
    .value_done_i   (value_done_o),
    .depth_now_i    (depth_now_o),
    .error_code_i   (error_code_o),
    .string_total_i (string_total_o),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_beats)
  );

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return 8'h20;
      1:       return ($urandom_range(0, 1) != 0) ? kvt_pkg::CH_LF : kvt_pkg::CH_CR;
      2:       return 8'($urandom_range(1, 32));
      default: return 8'($urandom_range(127, 255));
    endcase
  endfunction

  function automatic logic [7:0] ink_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == kvt_pkg::CH_QUOTE || c == kvt_pkg::CH_OPEN_BRACE ||
           c == kvt_pkg::CH_CLOSE_BRACE || c == kvt_pkg::CH_SLASH);
    return c;
  endfunction

  task automatic add_token();
    int         len;
    logic [7:0] c;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(kvt_pkg::CH_QUOTE);
      repeat (len) begin
        do c = 8'($urandom_range(1, 255)); while (c == kvt_pkg::CH_QUOTE);
        text_q.push_back(c);
      end
      text_q.push_back(kvt_pkg::CH_QUOTE);
      if ($urandom_range(0, 1) != 0) text_q.push_back(blank_char());
    end else begin
      repeat (len + 1) text_q.push_back(ink_char());
      text_q.push_back(blank_char());
    end
  endtask

  // Mostly well-formed text with random content; some noise and broken texts
  task automatic build_text();
    int         nest;
    logic [7:0] c;
    text_q.delete();
    nest = 0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            add_token();
            add_token();
          end
          5, 6: if (nest < 6) begin
            add_token();
            text_q.push_back(kvt_pkg::CH_OPEN_BRACE);
            nest++;
          end
          7: if (nest > 0) begin
            text_q.push_back(kvt_pkg::CH_CLOSE_BRACE);
            nest--;
          end
          8: begin
            text_q.push_back(kvt_pkg::CH_SLASH);
            text_q.push_back(kvt_pkg::CH_SLASH);
            repeat ($urandom_range(0, 6)) begin
              do c = 8'($urandom_range(1, 255));
              while (c == kvt_pkg::CH_CR || c == kvt_pkg::CH_LF);
              text_q.push_back(c);
            end
            text_q.push_back(($urandom_range(0, 1) != 0) ? kvt_pkg::CH_LF : kvt_pkg::CH_CR);
          end
          default: text_q.push_back(blank_char());
        endcase
      end
      if ($urandom_range(0, 5) != 0) repeat (nest) text_q.push_back(kvt_pkg::CH_CLOSE_BRACE);
      if ($urandom_range(0, 5) == 0)
        text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(1, 255)));
    end
    text_q.push_back(kvt_pkg::CH_NUL);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_byte(input logic [7:0] c);
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    data_byte_i <= c;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent_count++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_beats != 0);
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int texts;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_on  = 1'b1;
    stall_on = 1'b1;
    // key then quoted value around the byte range ends; comment, key closed by an
    // open brace, key cut off by the terminator inside a block; lone slash before
    // the terminator; open brace at key position; close brace at depth zero;
    // close brace at value position
    text_q = '{kvt_pkg::CH_FIRST_INK, 8'hFF, kvt_pkg::CH_QUOTE, kvt_pkg::CH_LAST_INK,
               kvt_pkg::CH_QUOTE, kvt_pkg::CH_NUL,
               kvt_pkg::CH_SLASH, kvt_pkg::CH_SLASH, 8'h7F, kvt_pkg::CH_CR, 8'h6B,
               kvt_pkg::CH_OPEN_BRACE, 8'h62, kvt_pkg::CH_NUL,
               kvt_pkg::CH_SLASH, kvt_pkg::CH_NUL,
               kvt_pkg::CH_OPEN_BRACE, 8'h20, kvt_pkg::CH_NUL,
               kvt_pkg::CH_CLOSE_BRACE, kvt_pkg::CH_NUL,
               8'h61, kvt_pkg::CH_CLOSE_BRACE, kvt_pkg::CH_NUL};
    send_text();

    // Nest to the depth limit, then one open too many
    text_q.delete();
    repeat (256) begin
      text_q.push_back(8'h61);
      text_q.push_back(kvt_pkg::CH_OPEN_BRACE);
    end
    text_q.push_back(kvt_pkg::CH_CLOSE_BRACE);
    text_q.push_back(8'h41);
    text_q.push_back(kvt_pkg::CH_NUL);
    send_text();

    texts = 0;
    while (sent_count < 1450) begin
      texts++;
      quiet    = (sent_count > 1250);
      idle_on  = ($urandom_range(0, 2) != 0);
      stall_on = ($urandom_range(0, 2) != 0);
      if (texts == 3) begin
        hold_req = 1'b1;
        idle_on  = 1'b0;
      end
      if (texts == 6) drain();
      build_text();
      send_text();
    end

    drain();
    repeat (6) @(negedge clk_i);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/kvt_pkg.sv
hdl/kvt_step.sv
hdl/keyvalue_text_tokenizer.sv
bench/keyvalue_text_tokenizer_checker.sv
bench/keyvalue_text_tokenizer_tb.sv
